// ----- rtl/core/rpwc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpwc_pkg
// Shared types and constants of the RC pulse width capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package rpwc_pkg;

  localparam int CH_BITS    = 3;
  localparam int CNT_BITS   = 16;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [CNT_BITS-1:0] PERIOD_RESET = 16'd40000;
  localparam logic [CNT_BITS-1:0] MIN_RESET    = 16'd2180;
  localparam logic [CNT_BITS-1:0] MAX_RESET    = 16'd3870;

  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_MIN    = 2'd1,
    REG_MAX    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] timer_period;
    logic [CNT_BITS-1:0] min_width;
    logic [CNT_BITS-1:0] max_width;
  } cfg_t;

  typedef struct packed {
    logic                expect_fall;
    logic [CNT_BITS-1:0] rise_time;
    logic [CNT_BITS-1:0] pulse_width;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/rpwc_in_if.sv -----
// ----------------------------------------------------------------------------
// rpwc_in_if
// Input channel: edge events and read requests with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpwc_in_if;
  import rpwc_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [CH_BITS-1:0]  channel;
  logic [CNT_BITS-1:0] count;

  modport source (output valid, output func, output channel, output count, input ready);
  modport sink   (input valid, input func, input channel, input count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rpwc_out_if.sv -----
// ----------------------------------------------------------------------------
// rpwc_out_if
// Output channel: measured pulse widths with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpwc_out_if;
  import rpwc_pkg::*;

  logic                valid;
  logic                ready;
  logic [CH_BITS-1:0]  read_channel;
  logic [CNT_BITS-1:0] value;

  modport source (output valid, output read_channel, output value, input ready);
  modport sink   (input valid, input read_channel, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rpwc_regs.sv -----
// ----------------------------------------------------------------------------
// rpwc_regs
// APB register file holding the timer period and the clamp bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwc_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rpwc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [rpwc_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [rpwc_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output rpwc_pkg::cfg_t                       cfg
);
  import rpwc_pkg::*;

  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_period <= PERIOD_RESET;
      cfg.min_width    <= MIN_RESET;
      cfg.max_width    <= MAX_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PERIOD: cfg.timer_period <= pwdata[CNT_BITS-1:0];
        REG_MIN:    cfg.min_width    <= pwdata[CNT_BITS-1:0];
        REG_MAX:    cfg.max_width    <= pwdata[CNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_PERIOD: prdata = APB_DATA_W'(cfg.timer_period);
      REG_MIN:    prdata = APB_DATA_W'(cfg.min_width);
      REG_MAX:    prdata = APB_DATA_W'(cfg.max_width);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/rc_pulse_width_capture.sv -----
// ----------------------------------------------------------------------------
// rc_pulse_width_capture
// Multichannel RC pulse width capture with clamped, mirrored read-back.
// ----------------------------------------------------------------------------
// One beat is accepted per cycle. Per-channel state sits in a small
// synchronous memory that is read when a beat is accepted; edge events are
// written back in the following cycle; a write forwarding register covers
// back-to-back beats on the same channel. A read result passes from the s1
// stage registers into the output register. The input stalls only while a
// read waits behind an output beat that has not been taken. Reset takes
// effect at once through per-entry valid bits, so no clearing pass is needed.
// Beats for channels at or above CHANNELS are dropped without a result.
`default_nettype none

module rc_pulse_width_capture #(
  parameter int CHANNELS = 7
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rpwc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [rpwc_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [rpwc_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  rpwc_in_if.sink                              in_ch,
  rpwc_out_if.source                           out_ch
);
  import rpwc_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_t cfg;

  rpwc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  entry_t              mem [CHANNELS];
  logic                ent_valid [CHANNELS];

  logic [4:0]          ch_ext;
  logic [CH_W-1:0]     in_idx;
  logic                in_range;
  logic                in_accept;

  logic                s1_valid;
  logic                s1_func;
  logic [CH_W-1:0]     s1_idx;
  logic [CH_BITS-1:0]  s1_channel;
  logic [CNT_BITS-1:0] s1_count;
  entry_t              rd_data;
  logic                rd_valid;

  logic                fwd_valid;
  logic [CH_W-1:0]     fwd_idx;
  entry_t              fwd_data;

  entry_t              cur;
  entry_t              new_entry;
  logic                s1_go;
  logic                wr_en;
  logic                out_load;

  logic [CNT_BITS:0]   sum;
  logic [CNT_BITS+1:0] diff;
  logic                wrap_sub;
  logic [CNT_BITS-1:0] width_calc;
  logic [CNT_BITS-1:0] clamped;
  logic [CNT_BITS-1:0] mirror;

  assign ch_ext    = {2'b00, in_ch.channel};
  assign in_idx    = ch_ext[CH_W-1:0];
  assign in_range  = ch_ext < 5'(CHANNELS);
  assign s1_go     = !(s1_valid && s1_func && out_ch.valid && !out_ch.ready);
  assign in_ch.ready = s1_go;
  assign in_accept = in_ch.valid && s1_go;
  assign wr_en     = s1_valid && !s1_func;
  assign out_load  = s1_valid && s1_func && s1_go;

  always_comb begin
    if (fwd_valid && (fwd_idx == s1_idx)) begin
      cur = fwd_data;
    end else if (rd_valid) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    sum        = {1'b0, cfg.timer_period} + {1'b0, s1_count};
    diff       = {1'b0, sum} - {2'b00, cur.rise_time};
    wrap_sub   = diff[CNT_BITS+1] || (diff[CNT_BITS:0] >= {1'b0, cfg.timer_period});
    width_calc = wrap_sub ? (s1_count - cur.rise_time) : diff[CNT_BITS-1:0];
  end

  always_comb begin
    new_entry = cur;
    if (!cur.expect_fall) begin
      new_entry.expect_fall = 1'b1;
      new_entry.rise_time   = s1_count;
    end else begin
      new_entry.expect_fall = 1'b0;
      new_entry.pulse_width = width_calc;
    end
  end

  always_comb begin
    if (cur.pulse_width < cfg.min_width) begin
      clamped = cfg.min_width;
    end else if (cur.pulse_width > cfg.max_width) begin
      clamped = cfg.max_width;
    end else begin
      clamped = cur.pulse_width;
    end
    mirror = cfg.max_width + cfg.min_width - clamped;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_idx] <= new_entry;
    end
    if (in_accept) begin
      rd_data  <= mem[in_idx];
      fwd_idx  <= s1_idx;
      fwd_data <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        ent_valid[k] <= 1'b0;
      end
    end else if (wr_en) begin
      ent_valid[s1_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      if (s1_go) begin
        s1_valid <= in_accept && in_range;
      end
      if (in_accept) begin
        fwd_valid <= wr_en;
        rd_valid  <= ent_valid[in_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func    <= in_ch.func;
      s1_idx     <= in_idx;
      s1_channel <= in_ch.channel;
      s1_count   <= in_ch.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.read_channel <= s1_channel;
      out_ch.value        <= mirror;
    end
  end

endmodule

`default_nettype wire
